/* rtl/u16pos_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16pos_pkg
// shared types and constants for the utf-16 position to byte offset mapper
// ----------------------------------------------------------------------------
package u16pos_pkg;

  localparam int POS_W = 21;

  localparam logic CFG_TARGET_LINE   = 1'b0;
  localparam logic CFG_TARGET_COLUMN = 1'b1;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_LINE,
    PH_DONE
  } phase_t;

  // number of bytes announced by a lead byte, one for anything malformed
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b[7] == 1'b0) len = 3'd1;
    else if (b[7:5] == 3'b110) len = 3'd2;
    else if (b[7:4] == 4'b1110) len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

endpackage

/* rtl/utf16_position_to_byte_offset_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_position_to_byte_offset_top
// maps a line and utf-16 column to a byte offset in a streamed utf-8 text
// ----------------------------------------------------------------------------
// Usage
//   cfg_we / cfg_index / cfg_wdata set target_line (index 0) and
//   target_column_units (index 1); write them while no text is in flight.
//   The text arrives one byte per item on in_valid / in_ready, with
//   in_last_byte set on its final byte. Exactly one item leaves on
//   out_valid / out_ready per text: the byte offset of the position.
//   Output: the result is registered and shows on out_valid in the cycle
//   after the byte that settles it is accepted (the final byte at the
//   latest). Throughput: one byte per cycle while no result waits, set by
//   the single decode and counter update pass from state to result registers.
//   Stall: while a result waits and out_ready is low, in_ready is low; as
//   soon as the result is taken, or in the same cycle, the next byte enters.
//   Bytes after the result are consumed silently until the final byte,
//   which rearms the counters for the next text.
//   Reset: synchronous on rst_n low; counters clear, targets go to zero,
//   no result is pending.
// ----------------------------------------------------------------------------
module utf16_position_to_byte_offset_top #(
  parameter longint unsigned MAX_TEXT = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [u16pos_pkg::POS_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [u16pos_pkg::POS_W-1:0] out_byte_offset
);
  import u16pos_pkg::*;

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_TEXT);

  typedef struct packed {
    logic          found;
    logic [CW-1:0] units;
    logic [CW-1:0] res;
  } flush_t;

  logic [POS_W-1:0] tline_r, tcol_r;
  logic [CW-1:0]    bytes_r, bytes_nxt;
  logic [CW-1:0]    lines_r, lines_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CW-1:0]    units_r, units_nxt;
  logic [7:0]       pend_r [3];
  logic [7:0]       pend_nxt [3];
  logic [1:0]       pc_r, pc_nxt;
  logic [2:0]       exp_r, exp_nxt;
  logic [CW-1:0]    cps_r, cps_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_offset_r, out_offset_nxt;
  logic             in_acc;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [1:0] n);
    logic [CW:0] sum;
    sum = (CW+1)'(v) + (CW+1)'(n);
    return (sum > (CW+1)'(MAXV)) ? MAXV : sum[CW-1:0];
  endfunction

  // buffered bytes of a broken sequence count one unit each
  function automatic flush_t flush(input logic [CW-1:0] u, input logic [1:0] pc,
                                   input logic [CW-1:0] cps, input logic [POS_W-1:0] tcol);
    flush_t f;
    logic [CW-1:0] u1, u2, u3;
    u1 = sat_add(u, 2'd1);
    u2 = sat_add(u, 2'd2);
    u3 = sat_add(u, 2'd3);
    f.found = 1'b0;
    f.res   = cps;
    case (pc)
      2'd0:    f.units = u;
      2'd1:    f.units = u1;
      2'd2:    f.units = u2;
      default: f.units = u3;
    endcase
    if (pc >= 2'd2 && XW'(u1) == XW'(tcol)) begin
      f.found = 1'b1;
      f.units = u1;
      f.res   = sat_add(cps, 2'd1);
    end else if (pc == 2'd3 && XW'(u2) == XW'(tcol)) begin
      f.found = 1'b1;
      f.units = u2;
      f.res   = sat_add(cps, 2'd2);
    end
    return f;
  endfunction

  assign in_ready        = !out_valid_r || out_ready;
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_byte_offset = out_offset_r;

  always_comb begin
    logic          have;
    logic          taken;
    logic          two;
    logic [CW-1:0] res;
    logic [2:0]    len;
    phase_t        ph_a;
    flush_t        fl;
    flush_t        fl_end;
    bytes_nxt   = bytes_r;
    lines_nxt   = lines_r;
    phase_nxt   = phase_r;
    units_nxt   = units_r;
    pend_nxt    = pend_r;
    pc_nxt      = pc_r;
    exp_nxt     = exp_r;
    cps_nxt     = cps_r;
    have        = 1'b0;
    taken       = 1'b0;
    two         = 1'b0;
    res         = '0;
    len         = lead_length(in_text_byte);
    ph_a        = phase_r;
    fl          = flush(units_r, pc_r, cps_r, tcol_r);
    fl_end      = '0;

    if (phase_r == PH_SEEK) begin
      if (XW'(lines_r) == XW'(tline_r)) ph_a = PH_LINE;
      else if (in_text_byte == NEWLINE_CHAR) lines_nxt = sat_add(lines_r, 2'd1);
    end
    phase_nxt = ph_a;

    if (ph_a == PH_LINE) begin
      if (pc_r != 2'd0) begin
        if (in_text_byte[7:6] == 2'b10) begin
          taken = 1'b1;
          if (({1'b0, pc_r} + 3'd1) >= exp_r || pc_r == 2'd3) begin
            two = (exp_r == 3'd4) && (pend_r[0][2:0] != 3'd0 || pend_r[1][5:4] != 2'd0);
            pc_nxt    = 2'd0;
            units_nxt = sat_add(units_r, two ? 2'd2 : 2'd1);
            if (XW'(units_nxt) > XW'(tcol_r)) begin
              have = 1'b1;
              res  = cps_r;
            end
          end else begin
            pend_nxt[pc_r] = in_text_byte;
            pc_nxt         = pc_r + 2'd1;
          end
        end else begin
          units_nxt = fl.units;
          pc_nxt    = 2'd0;
          if (fl.found) begin
            taken = 1'b1;
            have  = 1'b1;
            res   = fl.res;
          end
        end
      end
      if (!taken) begin
        if (in_text_byte == NEWLINE_CHAR || XW'(units_nxt) == XW'(tcol_r)) begin
          have = 1'b1;
          res  = bytes_r;
        end else if (len == 3'd1) begin
          units_nxt = sat_add(units_nxt, 2'd1);
        end else begin
          pend_nxt[0] = in_text_byte;
          pc_nxt      = 2'd1;
          exp_nxt     = len;
          cps_nxt     = bytes_r;
        end
      end
      if (have) phase_nxt = PH_DONE;
    end
    bytes_nxt = sat_add(bytes_r, 2'd1);

    if (in_last_byte) begin
      if (!have && phase_nxt != PH_DONE) begin
        if (phase_nxt == PH_LINE) begin
          fl_end = flush(units_nxt, pc_nxt, cps_nxt, tcol_r);
        end
        have = 1'b1;
        res  = fl_end.found ? fl_end.res : bytes_nxt;
      end
      bytes_nxt = '0;
      lines_nxt = '0;
      phase_nxt = PH_SEEK;
      units_nxt = '0;
      pc_nxt    = 2'd0;
      exp_nxt   = 3'd1;
      cps_nxt   = '0;
    end

    out_offset_nxt = out_offset_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (in_acc && have) begin
      out_valid_nxt  = 1'b1;
      out_offset_nxt = POS_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tline_r <= '0;
      tcol_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_LINE:   tline_r <= cfg_wdata;
        CFG_TARGET_COLUMN: tcol_r  <= cfg_wdata;
        default:           tline_r <= tline_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= '0;
      lines_r     <= '0;
      phase_r     <= PH_SEEK;
      units_r     <= '0;
      pc_r        <= 2'd0;
      exp_r       <= 3'd1;
      cps_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        bytes_r <= bytes_nxt;
        lines_r <= lines_nxt;
        phase_r <= phase_nxt;
        units_r <= units_nxt;
        pc_r    <= pc_nxt;
        exp_r   <= exp_nxt;
        cps_r   <= cps_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_offset_r <= out_offset_nxt;
    if (in_acc) pend_r <= pend_nxt;
  end

  a_pend_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != 2'd0 |-> phase_r == PH_LINE)
    else $error("bytes buffered outside the target line");

  a_pend_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != 2'd0 |-> exp_r > {1'b0, pc_r})
    else $error("buffered byte count reached the sequence length");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte && phase_r != PH_DONE |=> out_valid_r)
    else $error("final byte of an open search gave no result");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last_byte |=> phase_r == PH_SEEK && bytes_r == '0 && units_r == '0)
    else $error("final byte did not rearm the search");

endmodule
